// ===== rtl/gclp_pkg.sv =====
// Package for the cell lifetime profiler: shared codes, widths and the
// sequencer state type. No dependencies.
package gclp_pkg;

  localparam int TW = 7;  // width of a stored duration or age

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TR_BORN        = 2'd0,
    TR_STAYED_LIVE = 2'd1,
    TR_DIED        = 2'd2,
    TR_STAYED_DEAD = 2'd3
  } trans_t;

  localparam logic [2:0] SEL_DIED_AT   = 3'd0;
  localparam logic [2:0] SEL_ALIVE_AT  = 3'd1;
  localparam logic [2:0] SEL_ALIVE_DUR = 3'd2;
  localparam logic [2:0] SEL_DEAD_DUR  = 3'd3;
  localparam logic [2:0] SEL_AGE       = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_HIST1,
    ST_HIST2,
    ST_READ,
    ST_AGECLR,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/gc_cell_lifetime_profiler.sv =====
// Cell lifetime profiler top level: cell store, histogram memories and their
// read-modify-write sequencer. Depends on gclp_pkg.
//
// Each word names a cell (its slot, page type and mark bit), a histogram bin
// to read, or the start of a collection, and returns exactly one result word.
// The block holds per-cell state (used flag, state duration, age) and five
// 32-bit histograms in single-port-write, registered-read memories. After
// reset a clearing pass zeros all stores, during which in_ready stays low.
// An observation steps through cell read, histogram read, first write-back
// with the second duration read, second write-back and result hand-off: the
// two duration bins share one memory write port, which forces the second
// write-back. Beginning a collection sweeps the age histogram, one entry a
// cycle. A new word is accepted while the previous result still waits in
// the output register.
module gc_cell_lifetime_profiler
  import gclp_pkg::*;
#(
  parameter int CELLS     = 4096,
  parameter int NUM_KINDS = 18,
  parameter int MAX_TIME  = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [11:0]        cell_slot,
  input  logic [4:0]         cell_type,
  input  logic               marked,
  input  logic [2:0]         table_select,
  input  logic [6:0]         bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         transition,
  output logic [6:0]         cell_duration,
  output logic [6:0]         cell_age_bin,
  output logic signed [31:0] counter_value
);

  localparam int BINS    = MAX_TIME + 1;
  localparam int NB      = NUM_KINDS * BINS;
  localparam int AGW     = $clog2(NB);
  localparam int XW      = AGW + 1;
  localparam int CW      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CLR_LEN = (CELLS > 2 * NB) ? CELLS : 2 * NB;
  localparam int KW      = $clog2(CLR_LEN + 1);
  localparam int CSMALL  = (CELLS < 4096) ? CELLS : 4096;
  localparam int CWW     = 2 * TW + 1;

  // memories
  logic [CWW-1:0] cell_mem [CELLS];
  logic [31:0]    age_mem  [NB];
  logic [31:0]    tr_mem   [2*NB];
  logic [31:0]    du_mem   [2*NB];

  logic [CWW-1:0] cell_rdata;
  logic [31:0]    age_rdata, tr_rdata, du_rdata;

  logic [CW-1:0]  cell_raddr, cell_waddr;
  logic [AGW-1:0] age_raddr, age_waddr;
  logic [XW-1:0]  tr_raddr, tr_waddr, du_raddr, du_waddr;
  logic           cell_we, age_we, tr_we, du_we;
  logic [CWW-1:0] cell_wdata;
  logic [31:0]    age_wdata, tr_wdata, du_wdata;

  state_t state, state_next;
  logic [KW-1:0] clr_cnt;
  logic [1:0]    begun;

  // captured word
  logic [CW-1:0]  slot_q;
  logic [4:0]     type_q;
  logic           mark_q;
  logic [2:0]     sel_q;
  logic           rd_ok_q;

  // observation bookkeeping
  logic [AGW-1:0] age_idx_q;
  logic [XW-1:0]  tr_idx_q, d0_q;
  logic           age_en_q, tr_en_q, du_en_q;

  // result waiting for the output register
  logic [1:0]     res_tr;
  logic [6:0]     res_dur, res_age;
  logic [31:0]    res_cnt;

  logic           accept, out_free, clr_last;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign clr_last = (state == ST_CLEAR) ? (clr_cnt == KW'(CLR_LEN - 1))
                                        : (clr_cnt == KW'(NB - 1));

  // reduce the slot into the store's range
  logic [11:0] slot_mod;
  always_comb begin
    slot_mod = cell_slot;
    for (int k = 11; k >= 0; k--) begin
      if ((CSMALL << k) < 4096 && 32'(slot_mod) >= (CSMALL << k)) begin
        slot_mod = slot_mod - 12'(CSMALL << k);
      end
    end
  end

  // read-command addressing, from the ports
  logic           in_typed;
  logic [AGW-1:0] in_bidx;
  logic           in_rd_ok;
  assign in_typed = 32'(cell_type) < NUM_KINDS;
  assign in_bidx  = AGW'(AGW'(cell_type) * AGW'(BINS) + AGW'(bin_index));
  assign in_rd_ok = in_typed && 32'(bin_index) <= MAX_TIME && table_select <= SEL_AGE;

  // classify the observed cell from its stored word
  logic          c_use;
  logic [TW-1:0] c_time, c_age, c_age_cl, c_time_inc, c_age_inc;
  logic          c_first, c_typed, c_adv;
  logic [AGW-1:0] c_base;
  logic [1:0]    o_tr;
  logic [TW-1:0] o_time;
  logic          o_use, o_tr_en, o_du_en, o_alive, o_dead;
  logic [TW-1:0] o_tbin;
  logic [AGW-1:0] o_age_idx;
  logic [XW-1:0]  o_tr_idx, o_d0;

  always_comb begin
    c_use      = cell_rdata[2*TW];
    c_time     = cell_rdata[2*TW-1:TW];
    c_age      = cell_rdata[TW-1:0];
    c_age_cl   = (32'(c_age) > MAX_TIME) ? TW'(MAX_TIME) : c_age;
    c_time_inc = (32'(c_time) < MAX_TIME) ? c_time + TW'(1) : TW'(MAX_TIME);
    c_age_inc  = (32'(c_age_cl) < MAX_TIME) ? c_age_cl + TW'(1) : TW'(MAX_TIME);
    c_adv      = 32'(c_time) < MAX_TIME;
    c_first    = begun <= 2'd1;
    c_typed    = 32'(type_q) < NUM_KINDS;
    c_base     = AGW'(AGW'(type_q) * AGW'(BINS));
    o_use      = c_use;
    o_time     = c_time;
    o_tr_en    = 1'b0;
    o_du_en    = 1'b0;
    o_alive    = mark_q;
    o_dead     = !mark_q;
    o_tbin     = '0;
    if (!mark_q && c_use) begin
      o_tr    = TR_DIED;
      o_tr_en = 1'b1;
      o_tbin  = c_time_inc;
      o_use   = 1'b0;
      o_time  = '0;
    end else if (!mark_q) begin
      o_tr = TR_STAYED_DEAD;
      if (!c_first) begin
        o_tr_en = 1'b1;
        o_du_en = c_adv;
        o_time  = c_time_inc;
      end
    end else if (!c_use) begin
      o_tr    = TR_BORN;
      o_tr_en = !c_first;
      o_use   = 1'b1;
      o_time  = '0;
    end else begin
      o_tr    = TR_STAYED_LIVE;
      o_tr_en = 1'b1;
      o_tbin  = c_time_inc;
      o_du_en = c_adv;
      o_time  = c_time_inc;
    end
    o_age_idx = AGW'(c_base + AGW'(c_age_cl));
    o_tr_idx  = {AGW'(c_base + AGW'(o_tbin)), o_alive};
    o_d0      = XW'((o_dead ? XW'(NB) : XW'(0)) + XW'(c_base) + XW'(c_time));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(command))
            CMD_BEGIN:   state_next = ST_AGECLR;
            CMD_OBSERVE: state_next = ST_CELL;
            CMD_READ:    state_next = ST_READ;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_CELL:   state_next = ST_HIST1;
      ST_HIST1:  state_next = ST_HIST2;
      ST_HIST2:  state_next = ST_DONE;
      ST_READ:   state_next = ST_DONE;
      ST_AGECLR: if (clr_last) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    in_ready   = (state == ST_IDLE);
    cell_raddr = CW'(slot_mod);
    cell_we    = 1'b0;
    cell_waddr = slot_q;
    cell_wdata = {o_use, o_time, c_age_inc};
    age_raddr  = in_bidx;
    age_we     = 1'b0;
    age_waddr  = age_idx_q;
    age_wdata  = age_rdata + 32'd1;
    tr_raddr   = {in_bidx, table_select[0]};
    tr_we      = 1'b0;
    tr_waddr   = tr_idx_q;
    tr_wdata   = tr_rdata + 32'd1;
    du_raddr   = XW'((table_select[0] ? XW'(NB) : XW'(0)) + XW'(in_bidx));
    du_we      = 1'b0;
    du_waddr   = d0_q;
    du_wdata   = du_rdata - 32'd1;
    unique case (state)
      ST_CLEAR: begin
        // zero every store, each within its own depth
        cell_we    = 32'(clr_cnt) < CELLS;
        cell_waddr = CW'(clr_cnt);
        cell_wdata = '0;
        age_we     = 32'(clr_cnt) < NB;
        age_waddr  = AGW'(clr_cnt);
        age_wdata  = '0;
        tr_we      = 32'(clr_cnt) < 2 * NB;
        tr_waddr   = XW'(clr_cnt);
        tr_wdata   = '0;
        du_we      = 32'(clr_cnt) < 2 * NB;
        du_waddr   = XW'(clr_cnt);
        du_wdata   = '0;
      end
      ST_AGECLR: begin
        age_we    = 1'b1;
        age_waddr = AGW'(clr_cnt);
        age_wdata = '0;
      end
      ST_CELL: begin
        cell_we   = 1'b1;
        age_raddr = o_age_idx;
        tr_raddr  = o_tr_idx;
        du_raddr  = o_d0;
      end
      ST_HIST1: begin
        age_we   = age_en_q;
        tr_we    = tr_en_q;
        du_we    = du_en_q;
        du_raddr = d0_q + XW'(1);
      end
      ST_HIST2: begin
        du_we    = du_en_q;
        du_waddr = d0_q + XW'(1);
        du_wdata = du_rdata + 32'd1;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rdata <= cell_mem[cell_raddr];
  end
  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_waddr] <= age_wdata;
    age_rdata <= age_mem[age_raddr];
  end
  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    tr_rdata <= tr_mem[tr_raddr];
  end
  always_ff @(posedge clk) begin
    if (du_we) du_mem[du_waddr] <= du_wdata;
    du_rdata <= du_mem[du_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      begun     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_CLEAR || state == ST_AGECLR) && !clr_last) begin
        clr_cnt <= clr_cnt + KW'(1);
      end else begin
        clr_cnt <= '0;
      end
      if (accept && cmd_t'(command) == CMD_BEGIN && begun != 2'd3) begin
        begun <= begun + 2'd1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q  <= CW'(slot_mod);
      type_q  <= cell_type;
      mark_q  <= marked;
      sel_q   <= table_select;
      rd_ok_q <= in_rd_ok;
      res_tr  <= '0;
      res_dur <= '0;
      res_age <= '0;
      res_cnt <= '0;
    end
    if (state == ST_CELL) begin
      age_idx_q <= o_age_idx;
      tr_idx_q  <= o_tr_idx;
      d0_q      <= o_d0;
      age_en_q  <= c_typed;
      tr_en_q   <= c_typed && o_tr_en;
      du_en_q   <= c_typed && o_du_en;
      res_tr    <= o_tr;
      res_dur   <= 7'(o_time);
      res_age   <= 7'(c_age_cl);
    end
    if (state == ST_READ && rd_ok_q) begin
      unique case (sel_q) inside
        SEL_DIED_AT, SEL_ALIVE_AT:   res_cnt <= tr_rdata;
        SEL_ALIVE_DUR, SEL_DEAD_DUR: res_cnt <= du_rdata;
        default:                     res_cnt <= age_rdata;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      transition    <= res_tr;
      cell_duration <= res_dur;
      cell_age_bin  <= res_age;
      counter_value <= res_cnt;
    end
  end

  // the second duration write lands one bin above the first
  a_du_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HIST2 && du_we) |-> du_waddr == $past(du_waddr) + XW'(1))
    else $error("duration bins not adjacent");

  // the collection count never falls between resets
  a_begun_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> begun >= $past(begun))
    else $error("collection count fell");

  // histogram write-back only follows a cell read
  a_hist_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HIST1) |-> $past(state) == ST_CELL)
    else $error("histogram update out of order");

  // no word is taken while a sweep runs
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR || state == ST_AGECLR) |-> !in_ready)
    else $error("word accepted during clear");

endmodule
